// ----- hw/rtl/lab_pkg.sv -----
package lab_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int ROW_AW     = $clog2(MAX_HEIGHT);
	localparam int CNT_W      = ROW_AW + 1;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_STEP  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_SMIN   = 3'd2;
	localparam logic [2:0] REG_BIRTH  = 3'd3;
	localparam logic [2:0] REG_SMAX   = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_STEP,
		ST_DONE
	} state_t;

	// Next generation of one row from the rows above, at and below it.
	// Cells beyond either edge of the row count as dead.
	function automatic logic [MAX_WIDTH-1:0] next_row(
		input logic [MAX_WIDTH-1:0] up,
		input logic [MAX_WIDTH-1:0] mid,
		input logic [MAX_WIDTH-1:0] dn,
		input logic [3:0] smin,
		input logic [3:0] birth,
		input logic [3:0] smax
	);
		logic [MAX_WIDTH+1:0] u;
		logic [MAX_WIDTH+1:0] m;
		logic [MAX_WIDTH+1:0] d;
		logic [3:0] n;
		logic [MAX_WIDTH-1:0] r;
		u = {1'b0, up, 1'b0};
		m = {1'b0, mid, 1'b0};
		d = {1'b0, dn, 1'b0};
		r = '0;
		for (int x = 0; x < MAX_WIDTH; x++) begin
			n = 4'(u[x]) + 4'(u[x+1]) + 4'(u[x+2]) + 4'(m[x]) + 4'(m[x+2])
				+ 4'(d[x]) + 4'(d[x+1]) + 4'(d[x+2]);
			if (n < smin) begin
				r[x] = 1'b0;
			end else if (n == birth) begin
				r[x] = 1'b1;
			end else if (n > smax) begin
				r[x] = 1'b0;
			end else begin
				r[x] = m[x+1];
			end
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/lab_ram.sv -----
module lab_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/life_automaton_board_top.sv -----
// Channel  Direction  Handshake           Payload
// in       receive    in_valid/in_stall   command, offset_x, offset_y, cell_alive, row_index
// out      send       out_valid/out_stall row_bits, generation_parity
// cfg      receive    cfg_we              cfg_index, cfg_data
//
// A write or read command passes through the access and done states to its result; a step
// sweeps one row a cycle through the board RAM before it reaches the done state.
// Reset clears parity and the row valid bits and sets the registers to their defaults; no clearing pass is needed.
// A waiting result is held in the output register while the next item is accepted.
module life_automaton_board_top import lab_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             command,
	input  logic signed [6:0]      offset_x,
	input  logic signed [6:0]      offset_y,
	input  logic                   cell_alive,
	input  logic [5:0]             row_index,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [MAX_WIDTH-1:0]   row_bits,
	output logic                   generation_parity,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [6:0]             cfg_data
);

	state_t state_q, state_d;

	logic [6:0] width_q, height_q;
	logic [3:0] smin_q, birth_q, smax_q;
	logic       parity_q;

	logic [MAX_HEIGHT-1:0] val_even_q, val_odd_q;
	logic                  vld_s1;

	cmd_t                  cmd_q;
	logic [5:0]            x_q;
	logic [ROW_AW-1:0]     y_q;
	logic                  alive_q, hit_q;
	logic [MAX_WIDTH-1:0]  res_row_q;

	logic [CNT_W-1:0]      sc_q, sc_s1;
	logic                  sv_s1;
	logic [MAX_WIDTH-1:0]  win_up_q, win_mid_q;

	logic [6:0]            ew, eh;
	logic [MAX_WIDTH-1:0]  wmask;
	logic signed [8:0]     xs, ys;

	logic [ROW_AW-1:0]     raddr, waddr;
	logic [MAX_WIDTH-1:0]  wdata, rd_even, rd_odd, row_v, row_m, below, nrow;
	logic                  we_cur, we_dst, we_even, we_odd;
	logic                  accept, step_last, out_load;
	logic [ROW_AW-1:0]     step_row;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_load = (state_q == ST_DONE) && (!out_valid || !out_stall);

	// Effective board size, width mask and centred cell coordinates
	always_comb begin
		ew = (width_q == 7'd0) ? 7'd1 : (width_q > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width_q;
		eh = (height_q == 7'd0) ? 7'd1 :
			(height_q > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : height_q;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			wmask[i] = (7'(i) < ew);
		end
		xs = $signed({3'b000, ew[6:1]}) + 9'(offset_x);
		ys = $signed({3'b000, eh[6:1]}) + 9'(offset_y);
	end

	assign row_v = (parity_q ? rd_odd : rd_even) & {MAX_WIDTH{vld_s1}};
	assign row_m = row_v & wmask;
	assign below = (sc_s1 < CNT_W'(eh)) ? row_m : '0;
	assign step_row = ROW_AW'(sc_s1 - CNT_W'(1));
	assign nrow = (CNT_W'(step_row) < CNT_W'(eh)) ?
		(next_row(win_up_q, win_mid_q, below, smin_q, birth_q, smax_q) & wmask) : '0;
	assign step_last = sv_s1 && (sc_s1 == CNT_W'(MAX_HEIGHT));

	always_comb begin
		state_d = state_q;
		raddr   = y_q;
		waddr   = y_q;
		wdata   = row_v;
		we_cur  = 1'b0;
		we_dst  = 1'b0;
		wdata[x_q] = alive_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd_t'(command))
						CMD_WRITE: begin
							raddr   = ys[ROW_AW-1:0];
							state_d = ST_ACCESS;
						end
						CMD_READ: begin
							raddr   = row_index;
							state_d = ST_ACCESS;
						end
						CMD_STEP: state_d = ST_STEP;
						CMD_NONE: state_d = ST_DONE;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_ACCESS: begin
				we_cur  = (cmd_q == CMD_WRITE) && hit_q;
				state_d = ST_DONE;
			end
			ST_STEP: begin
				raddr  = sc_q[ROW_AW-1:0];
				waddr  = step_row;
				wdata  = nrow;
				we_dst = sv_s1 && (sc_s1 != '0);
				if (step_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign we_even = parity_q ? we_dst : we_cur;
	assign we_odd  = parity_q ? we_cur : we_dst;

	lab_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_even (
		.clk(clk), .we(we_even), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd_even)
	);

	lab_ram #(.WIDTH(MAX_WIDTH), .DEPTH(MAX_HEIGHT)) u_odd (
		.clk(clk), .we(we_odd), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd_odd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= 7'd64;
			height_q   <= 7'd64;
			smin_q     <= 4'd2;
			birth_q    <= 4'd3;
			smax_q     <= 4'd3;
			parity_q   <= 1'b0;
			val_even_q <= '0;
			val_odd_q  <= '0;
			vld_s1     <= 1'b0;
			sv_s1      <= 1'b0;
			sc_q       <= '0;
			sc_s1      <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					REG_SMIN:   smin_q   <= cfg_data[3:0];
					REG_BIRTH:  birth_q  <= cfg_data[3:0];
					REG_SMAX:   smax_q   <= cfg_data[3:0];
					default: ;
				endcase
			end
			vld_s1 <= parity_q ? val_odd_q[raddr] : val_even_q[raddr];
			if (we_even) begin
				val_even_q[waddr] <= 1'b1;
			end
			if (we_odd) begin
				val_odd_q[waddr] <= 1'b1;
			end
			sv_s1 <= (state_q == ST_STEP);
			sc_s1 <= sc_q;
			if (accept) begin
				sc_q <= '0;
			end else if ((state_q == ST_STEP) && (sc_q != CNT_W'(MAX_HEIGHT))) begin
				sc_q <= sc_q + CNT_W'(1);
			end
			if ((state_q == ST_STEP) && step_last) begin
				parity_q <= !parity_q;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd_t'(command);
			x_q       <= xs[5:0];
			// A read addresses its row directly; a write addresses it from the centre.
			y_q       <= (cmd_t'(command) == CMD_READ) ? row_index : ys[ROW_AW-1:0];
			alive_q   <= cell_alive;
			hit_q     <= (xs >= 0) && (xs < $signed({2'b00, ew})) &&
				(ys >= 0) && (ys < $signed({2'b00, eh}));
			res_row_q <= '0;
			win_up_q  <= '0;
			win_mid_q <= '0;
		end
		if ((state_q == ST_ACCESS) && (cmd_q == CMD_READ)) begin
			res_row_q <= (7'(y_q) < eh) ? row_m : '0;
		end
		if ((state_q == ST_STEP) && sv_s1) begin
			win_up_q  <= win_mid_q;
			win_mid_q <= below;
		end
		if (out_load) begin
			row_bits          <= res_row_q;
			generation_parity <= parity_q;
		end
	end

endmodule

// ----- hw/rtl/lab_checker.sv -----
module lab_checker import lab_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [1:0]           command,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [MAX_WIDTH-1:0] row_bits
);

	// A held result keeps its valid.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(row_bits))
		else $error("stalled result changed");

	// Every item keeps the block busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted on consecutive cycles");

	// A step sweeps the whole board, so the block stays busy while the sweep runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (command == CMD_STEP) |=> in_stall ##1 in_stall)
		else $error("step finished too early");

endmodule

bind life_automaton_board_top lab_checker u_lab_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.command(command), .out_valid(out_valid), .out_stall(out_stall), .row_bits(row_bits)
);
